[sv/sdsplit_pkg.sv]
// Shared types, constants and helper functions for the delimiter splitter.
`default_nettype none

package sdsplit_pkg;

  // Default sizing of the block.
  localparam int MAX_DELIM_DEF = 4;
  localparam int POS_BITS_DEF  = 16;

  // Width of the delimiter register and of the output fields.
  localparam int DELIM_W = 32;
  localparam int FIELD_W = 16;

  // Configuration register indexes.
  localparam logic [1:0] REG_DELIM_BYTES  = 2'd0;
  localparam logic [1:0] REG_DELIM_LENGTH = 2'd1;
  localparam logic [1:0] REG_STRICT_MODE  = 2'd2;

  // Result queue sizing.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One input transaction.
  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_string;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [FIELD_W-1:0] token_offset;
    logic [FIELD_W-1:0] token_length;
    logic               final_token;
  } out_item_t;

  // Control from the top level to every history cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // Up to two results pushed into the queue in one cycle; slot a goes first.
  typedef struct packed {
    logic      a_valid;
    logic      b_valid;
    out_item_t a;
    out_item_t b;
  } q_push_t;

  // Delimiter byte k; positions past the fourth byte read as zero.
  function automatic logic [7:0] delim_byte(input logic [DELIM_W-1:0] bytes,
                                            input logic [3:0] idx);
    logic [DELIM_W-1:0] sh;
    sh = bytes >> {idx[1:0], 3'b000};
    return (idx[3:2] != 2'b00) ? 8'h00 : sh[7:0];
  endfunction

endpackage

`default_nettype wire

[sv/strict_delimiter_splitter_top.sv]
// Top level of the multi-byte delimiter splitter.
`default_nettype none

// The block takes one string byte per cycle while the queue has room and reports a token
// (start offset and length) for every delimiter match, plus a final remainder token on
// the last byte. Past bytes live in a row of MAX_DELIM history cells that shift on each
// accepted transaction and compare against the delimiter in parallel, so a byte can be
// taken every cycle. Results are registered in a four-entry queue and leave one per
// cycle while out_ready is high; input is taken while the queue has two free entries,
// so a byte that yields two results (a split and the final token) takes two entries.
// In strict mode a match is reported when the following byte arrives, or at once on
// the final byte. Configuration writes take effect in the next cycle.
module strict_delimiter_splitter_top #(
  parameter int MAX_DELIM = sdsplit_pkg::MAX_DELIM_DEF,
  parameter int POS_BITS  = sdsplit_pkg::POS_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire sdsplit_pkg::in_item_t             in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output sdsplit_pkg::out_item_t                 out_data,
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [sdsplit_pkg::DELIM_W-1:0]   cfg_wdata
);

  localparam int LW    = $clog2(MAX_DELIM + 1);
  localparam int CMP_W = (LW > 3) ? LW : 3;
  localparam int PW    = POS_BITS;
  localparam logic [PW-1:0] POS_MAX = '1;

  // Configuration registers.
  logic [sdsplit_pkg::DELIM_W-1:0] delimiter_bytes;
  logic [2:0]                      delimiter_length;
  logic                            strict_mode;

  // String state.
  logic [PW-1:0] byte_position;
  logic [PW-1:0] current_start;
  logic          match_waiting;
  logic [PW-1:0] waiting_match_pos;

  logic                   accept;
  logic                   eos;
  logic [7:0]             ch;
  logic [LW-1:0]          lclip;
  logic [CMP_W-1:0]       dl_ext;
  logic                   len_nz;
  logic [7:0]             last;
  logic [PW-1:0]          len_pos;
  logic [PW-1:0]          lm1_pos;
  logic [PW:0]            count_sum;
  logic [PW-1:0]          count;
  logic [7:0]             new_byte [MAX_DELIM+1];
  logic [7:0]             held     [MAX_DELIM];
  logic [MAX_DELIM-1:0]   eq;
  logic [7:0]             before_byte;
  logic                   hit;
  logic                   before_bad;
  logic [PW-1:0]          start;
  logic                   wait_take;
  logic                   new_split;
  logic                   set_wait;
  logic                   split_valid;
  logic [PW-1:0]          split_pos;
  logic [PW-1:0]          tok_len;
  logic [PW:0]            end_sum;
  logic [PW-1:0]          split_end;
  logic [PW-1:0]          cs_after;
  logic [PW-1:0]          rem_len;
  logic                   room;
  sdsplit_pkg::cell_ctl_t ctl;
  sdsplit_pkg::out_item_t split_item;
  sdsplit_pkg::out_item_t final_item;
  sdsplit_pkg::q_push_t   push;

  assign ch       = in_data.char_in;
  assign eos      = in_data.end_of_string;
  assign in_ready = room;
  assign accept   = in_valid && in_ready;

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_bytes  <= '0;
      delimiter_length <= 3'd1;
      strict_mode      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sdsplit_pkg::REG_DELIM_BYTES:  delimiter_bytes  <= cfg_wdata;
        sdsplit_pkg::REG_DELIM_LENGTH: delimiter_length <= cfg_wdata[2:0];
        sdsplit_pkg::REG_STRICT_MODE:  strict_mode      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Effective length, clipped to the number of cells, and the last delimiter byte.
  always_comb begin
    dl_ext  = CMP_W'(delimiter_length);
    lclip   = (dl_ext > CMP_W'(MAX_DELIM)) ? LW'(MAX_DELIM) : LW'(dl_ext);
    len_nz  = (lclip != '0);
    last    = len_nz ? sdsplit_pkg::delim_byte(delimiter_bytes, 4'(lclip - LW'(1)))
                     : 8'h00;
    len_pos = PW'(lclip);
    lm1_pos = len_pos - PW'(1);
  end

  // Byte count including this byte, saturating.
  always_comb begin
    count_sum = {1'b0, byte_position} + (PW+1)'(1);
    count     = count_sum[PW] ? POS_MAX : count_sum[PW-1:0];
  end

  // History cell chain: cell k sees the byte that will become history entry k.
  assign ctl.shift   = accept;
  assign ctl.clear   = accept && eos;
  assign new_byte[0] = ch;

  for (genvar k = 0; k < MAX_DELIM; k++) begin : g_cell
    sdsplit_cell #(
      .IDX (k),
      .LW  (LW)
    ) u_cell (
      .clk             (clk),
      .rst             (rst),
      .ctl             (ctl),
      .in_byte         (new_byte[k]),
      .len             (lclip),
      .delimiter_bytes (delimiter_bytes),
      .held            (held[k]),
      .eq              (eq[k])
    );
    assign new_byte[k+1] = held[k];
  end

  // The byte just before a match of the current length.
  always_comb begin
    before_byte = 8'h00;
    for (int k = 0; k < MAX_DELIM; k++) begin
      if (lclip == LW'(k + 1)) begin
        before_byte = held[k];
      end
    end
  end

  // Match detection and the strict-mode decisions.
  always_comb begin
    hit         = len_nz && (count >= len_pos) && (&eq);
    before_bad  = (count > len_pos) && (before_byte == last);
    start       = (byte_position >= lm1_pos) ? byte_position - lm1_pos : '0;
    wait_take   = match_waiting && len_nz && (ch != last);
    new_split   = hit && (!strict_mode || (!before_bad && eos));
    set_wait    = hit && strict_mode && !before_bad && !eos;
    split_valid = wait_take || new_split;
    split_pos   = wait_take ? waiting_match_pos : start;
  end

  // Token arithmetic: split token, new start and remainder.
  always_comb begin
    tok_len   = (split_pos >= current_start) ? split_pos - current_start : '0;
    end_sum   = {1'b0, split_pos} + {1'b0, len_pos};
    split_end = end_sum[PW] ? POS_MAX : end_sum[PW-1:0];
    cs_after  = split_valid ? split_end : current_start;
    rem_len   = (count >= cs_after) ? count - cs_after : '0;
  end

  // Results for the queue, split token ahead of the final token.
  always_comb begin
    split_item.token_offset = sdsplit_pkg::FIELD_W'(current_start);
    split_item.token_length = sdsplit_pkg::FIELD_W'(tok_len);
    split_item.final_token  = 1'b0;
    final_item.token_offset = sdsplit_pkg::FIELD_W'(cs_after);
    final_item.token_length = sdsplit_pkg::FIELD_W'(rem_len);
    final_item.final_token  = 1'b1;
    push.a_valid = accept && (split_valid || eos);
    push.b_valid = accept && split_valid && eos;
    push.a       = split_valid ? split_item : final_item;
    push.b       = final_item;
  end

  // String state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      current_start     <= '0;
      match_waiting     <= 1'b0;
      waiting_match_pos <= '0;
    end else if (accept) begin
      if (eos) begin
        byte_position     <= '0;
        current_start     <= '0;
        match_waiting     <= 1'b0;
        waiting_match_pos <= '0;
      end else begin
        byte_position <= count;
        current_start <= cs_after;
        match_waiting <= set_wait;
        if (set_wait) begin
          waiting_match_pos <= start;
        end
      end
    end
  end

  sdsplit_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[sv/sdsplit_cell.sv]
// One history cell: holds one past byte and compares its incoming byte.
`default_nettype none

module sdsplit_cell #(
  parameter int IDX = 0,
  parameter int LW  = 3
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire sdsplit_pkg::cell_ctl_t             ctl,
  input  wire logic [7:0]                         in_byte,
  input  wire logic [LW-1:0]                      len,
  input  wire logic [sdsplit_pkg::DELIM_W-1:0]    delimiter_bytes,
  output logic [7:0]                              held,
  output logic                                    eq
);

  localparam logic [LW-1:0] IDX_L = LW'(IDX);

  logic [LW-1:0] didx;

  // Byte register, shifted toward the next cell on every accepted transaction.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      held <= 8'h00;
    end else if (ctl.shift) begin
      held <= in_byte;
    end
  end

  // This cell checks delimiter byte len-1-IDX; cells past the length always agree.
  always_comb begin
    didx = len - IDX_L - LW'(1);
    if (len <= IDX_L) begin
      eq = 1'b1;
    end else begin
      eq = (in_byte == sdsplit_pkg::delim_byte(delimiter_bytes, 4'(didx)));
    end
  end

endmodule

`default_nettype wire

[sv/sdsplit_queue.sv]
// Small result queue: up to two in a cycle, one out while out_ready is high.
`default_nettype none

module sdsplit_queue (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire sdsplit_pkg::q_push_t    push,
  output logic                         room,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output sdsplit_pkg::out_item_t       out_data
);

  sdsplit_pkg::out_item_t slots [sdsplit_pkg::QDEPTH];

  logic [sdsplit_pkg::QPTR_W-1:0] head;
  logic [sdsplit_pkg::QPTR_W-1:0] tail;
  logic [sdsplit_pkg::QCNT_W-1:0] count;
  logic [sdsplit_pkg::QPTR_W-1:0] tail_next;
  logic [sdsplit_pkg::QCNT_W-1:0] count_next;
  logic                           pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_data  = slots[head];
  assign room      = (count <= sdsplit_pkg::QCNT_W'(sdsplit_pkg::QDEPTH - 2));

  // Pointer and fill bookkeeping.
  always_comb begin
    tail_next  = tail + sdsplit_pkg::QPTR_W'(push.a_valid)
                      + sdsplit_pkg::QPTR_W'(push.b_valid);
    count_next = count + sdsplit_pkg::QCNT_W'(push.a_valid)
                       + sdsplit_pkg::QCNT_W'(push.b_valid)
                       - sdsplit_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail_next;
      count <= count_next;
      if (pop) begin
        head <= head + sdsplit_pkg::QPTR_W'(1);
      end
    end
  end

  // Storage writes; slot b lands right behind slot a.
  always_ff @(posedge clk) begin
    if (push.a_valid) begin
      slots[tail] <= push.a;
    end
    if (push.b_valid) begin
      slots[tail + sdsplit_pkg::QPTR_W'(1)] <= push.b;
    end
  end

endmodule

`default_nettype wire

[bench/tb_strict_delimiter_splitter_top.sv]
// Self-checking testbench for the delimiter splitter with a local token predictor.
module tb_strict_delimiter_splitter_top;
  import sdsplit_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int HOLD_CYCLES    = 400;
  localparam int POS_LIMIT      = 65535;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_BYTES    = 90;

  // Block ports; the inputs are driven to known values from time zero.
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               cfg_we    = 1'b0;
  logic [1:0]         cfg_index = REG_DELIM_BYTES;
  logic [DELIM_W-1:0] cfg_wdata = '0;

  // Local copy of the registers, as last written.
  logic [DELIM_W-1:0] delim_reg     = '0;
  logic [2:0]         delim_len_reg = 3'd1;
  logic               strict_reg    = 1'b0;

  // Predictor state for the string in progress.
  logic [7:0] recent [0:MAX_DELIM_DEF];
  int         byte_count = 0;
  int         tok_start  = 0;
  int         held_at    = 0;
  logic       held       = 1'b0;

  // Bytes waiting to be sent and tokens waiting to come out.
  in_item_t  pending_bytes [$];
  out_item_t tokens_due [$];

  // Run control shared between the stimulus flow and the clocked processes.
  int   mismatch_cnt      = 0;
  int   sender_idle_pct   = 0;
  int   receiver_idle_pct = 0;
  logic hold_request      = 1'b0;
  logic hold_started      = 1'b0;
  int   hold_left         = 0;
  int   stall_left        = 0;
  int   gap_left          = 0;
  int   quiet_cycles      = 0;

  strict_delimiter_splitter_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin : clock_gen
    forever #1 clk = ~clk;
  end

  // Delimiter length in use; longer settings fall back to the maximum.
  function automatic int active_len();
    return (delim_len_reg > MAX_DELIM_DEF) ? MAX_DELIM_DEF : int'(delim_len_reg);
  endfunction

  function automatic logic [7:0] delim_char(input int k);
    return delim_reg[8*k +: 8];
  endfunction

  function automatic void clear_string();
    foreach (recent[k]) recent[k] = 8'h00;
    byte_count = 0;
    tok_start  = 0;
    held       = 1'b0;
    held_at    = 0;
  endfunction

  function automatic void emit_token(input int off, input int len, input logic fin);
    out_item_t tok;
    tok.token_offset = 16'(off);
    tok.token_length = 16'(len);
    tok.final_token  = fin;
    tokens_due.push_back(tok);
  endfunction

  // A token ends where a match starts; the next token starts just past the match.
  function automatic void split_token(input int at, input int len);
    emit_token(tok_start, (at >= tok_start) ? at - tok_start : 0, 1'b0);
    tok_start = (at + len > POS_LIMIT) ? POS_LIMIT : at + len;
  endfunction

  // Work out the tokens that one accepted byte causes.
  function automatic void split_byte(input in_item_t it);
    int         dl;
    int         cur;
    int         cnt;
    int         at;
    int         j;
    logic [7:0] last_ch;
    logic       hit;
    dl      = active_len();
    last_ch = (dl > 0) ? delim_char(dl - 1) : 8'h00;
    cur     = byte_count;
    cnt     = (cur >= POS_LIMIT) ? POS_LIMIT : cur + 1;
    for (j = MAX_DELIM_DEF; j > 0; j--) recent[j] = recent[j-1];
    recent[0] = it.char_in;

    // A strict match held from the previous byte is settled by this byte.
    if (held) begin
      held = 1'b0;
      if (dl > 0 && it.char_in != last_ch) split_token(held_at, dl);
    end

    if (dl > 0 && cnt >= dl) begin
      hit = 1'b1;
      for (j = 0; j < dl; j++) begin
        if (recent[dl-1-j] != delim_char(j)) hit = 1'b0;
      end
      if (hit) begin
        at = (cur >= dl - 1) ? cur - (dl - 1) : 0;
        if (!strict_reg) begin
          split_token(at, dl);
        end else if (!(cnt > dl && recent[dl] == last_ch)) begin
          // With no byte after the end of the string, the match stands at once.
          if (it.end_of_string) begin
            split_token(at, dl);
          end else begin
            held    = 1'b1;
            held_at = at;
          end
        end
      end
    end

    if (it.end_of_string) begin
      emit_token(tok_start, (cnt >= tok_start) ? cnt - tok_start : 0, 1'b1);
      clear_string();
    end else begin
      byte_count = cnt;
    end
  endfunction

  function automatic void report_token(input string why, input out_item_t due,
                                       input out_item_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%s: expected off=%0d len=%0d fin=%0b, got off=%0d len=%0d fin=%0b",
               why, due.token_offset, due.token_length, due.final_token,
               got.token_offset, got.token_length, got.final_token);
  endfunction

  // Driver: offers pending bytes, with random gaps between transactions.
  always @(posedge clk) begin : byte_driver
    logic nxt_valid;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && in_ready) begin
        void'(pending_bytes.pop_front());
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
          gap_left = $urandom_range(1, 11) - 1;
        end else if (pending_bytes.size() != 0) begin
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
      if (nxt_valid) in_data <= pending_bytes[0];
    end
  end

  // Monitor: predicts on each input transaction, then checks each output transaction.
  always @(posedge clk) begin : token_monitor
    out_item_t due;
    logic      nxt_ready;
    if (rst) begin
      out_ready <= 1'b0;
      clear_string();
      tokens_due.delete();
    end else begin
      if (in_valid && in_ready) split_byte(in_data);

      if (out_valid && out_ready) begin
        if (tokens_due.size() == 0) begin
          due = '0;
          report_token("unexpected token", due, out_data);
        end else begin
          due = tokens_due.pop_front();
          if (out_data.token_offset !== due.token_offset ||
              out_data.token_length !== due.token_length ||
              out_data.final_token !== due.final_token)
            report_token("token mismatch", due, out_data);
        end
      end

      // Receiver back-pressure: one long hold-off on request, else short bursts.
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (hold_request && !hold_started) begin
        hold_started = 1'b1;
        hold_left    = HOLD_CYCLES - 1;
        nxt_ready    = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else if (receiver_idle_pct != 0 && $urandom_range(0, 99) < receiver_idle_pct) begin
        stall_left = $urandom_range(1, 11) - 1;
        nxt_ready  = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      out_ready <= nxt_ready;
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic void push_byte(input logic [7:0] c, input logic eos);
    in_item_t it;
    it.char_in       = c;
    it.end_of_string = eos;
    pending_bytes.push_back(it);
  endfunction

  task automatic queue_str(input string s, input logic eos);
    int k;
    for (k = 0; k < s.len(); k++) push_byte(s[k], eos && k == s.len() - 1);
  endtask

  // A zero byte never appears in a string, so it is replaced by a random one.
  function automatic logic [7:0] as_char(input logic [7:0] c);
    return (c == 8'h00) ? 8'($urandom_range(1, 255)) : c;
  endfunction

  // Register write: raise the write enable with index and data, then the local copy follows.
  task automatic write_reg(input logic [1:0] idx, input logic [DELIM_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    case (idx)
      REG_DELIM_BYTES:  delim_reg     = val;
      REG_DELIM_LENGTH: delim_len_reg = val[2:0];
      REG_STRICT_MODE:  strict_reg    = val[0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (2) @(negedge clk);
  endtask

  // Unused upper bits of the narrow registers carry random values.
  task automatic set_config(input logic [31:0] bytes, input logic [2:0] len,
                            input logic strict);
    logic [31:0] noise;
    noise = $urandom;
    write_reg(REG_DELIM_BYTES, bytes);
    write_reg(REG_DELIM_LENGTH, {noise[31:3], len});
    write_reg(REG_STRICT_MODE, {noise[30:0], strict});
    end_writes();
  endtask

  task automatic random_config();
    logic [31:0] bytes;
    logic [2:0]  len;
    int          r;
    int          k;
    r   = $urandom_range(0, 9);
    len = (r == 0) ? 3'd0 : (r == 1) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(1, 4));
    for (k = 0; k < 4; k++)
      bytes[8*k +: 8] = $urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h63))
                                             : 8'($urandom_range(0, 255));
    set_config(bytes, len, 1'($urandom_range(0, 1)));
  endtask

  // Mostly strings built from delimiter copies and its own bytes, with some noise strings.
  task automatic queue_random_text(input int budget);
    logic [7:0] txt [$];
    int         left;
    int         want;
    int         dl;
    int         k;
    int         r;
    logic       noisy;
    logic       runs_on;
    dl   = active_len();
    left = budget;
    while (left > 0) begin
      want = $urandom_range(1, 24);
      if (want > left) want = left;
      noisy = ($urandom_range(0, 5) == 0);
      txt.delete();
      while (txt.size() < want) begin
        r = noisy ? 9 : $urandom_range(0, 9);
        if (r <= 2) begin
          for (k = 0; k < dl; k++) txt.push_back(as_char(delim_char(k)));
        end else if (r <= 5 && dl > 0) begin
          txt.push_back(as_char(delim_char(dl - 1)));
        end else if (r <= 7 && dl > 0) begin
          txt.push_back(as_char(delim_char(0)));
        end else begin
          txt.push_back(8'($urandom_range(1, 255)));
        end
      end
      // The last string of a batch sometimes runs on into the next setting.
      runs_on = (want == left) && ($urandom_range(0, 3) == 0);
      for (k = 0; k < want; k++) push_byte(txt[k], k == want - 1 && !runs_on);
      left -= want;
    end
  endtask

  // Wait until every byte is taken and every token is out, then let the block settle.
  task automatic drain();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || tokens_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic int pick_idle_pct();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
  endfunction

  initial begin : stimulus
    int phase;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Settings after reset: a zero delimiter byte never matches.
    queue_str("ab", 1'b1);
    drain();

    // Single-byte delimiter at offset zero, back to back and on the last byte.
    set_config(32'h0000_002C, 3'd1, 1'b0);
    queue_str(",,a,", 1'b1);
    drain();

    // Overlapping matches give a token whose start lies past the match.
    set_config(32'h0061_6261, 3'd3, 1'b0);
    queue_str("ababa", 1'b1);
    drain();

    // Strict mode: rejected by the byte before, by the byte after, and kept at the end.
    set_config(32'h0000_7978, 3'd2, 1'b1);
    queue_str("yxyaxyyaxy", 1'b1);
    drain();

    // Zero length never splits.
    set_config(32'h0000_00AB, 3'd0, 1'b0);
    queue_str("q", 1'b1);
    drain();

    // Oversized length with extreme byte values.
    set_config(32'h01FF_01FF, 3'd7, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b1);
    drain();

    // A held strict match meets a zero length, then a cleared strict mode.
    set_config(32'h0000_6261, 3'd2, 1'b1);
    queue_str("ab", 1'b0);
    drain();
    write_reg(REG_DELIM_LENGTH, 32'd0);
    end_writes();
    queue_str("c", 1'b1);
    drain();
    set_config(32'h0000_6261, 3'd2, 1'b1);
    queue_str("ab", 1'b0);
    drain();
    write_reg(REG_STRICT_MODE, 32'd0);
    end_writes();
    queue_str("z", 1'b1);
    drain();

    // Random settings and strings; one phase holds the receiver off for a long time.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_config();
      sender_idle_pct   = pick_idle_pct();
      receiver_idle_pct = pick_idle_pct();
      if (phase == 2) begin
        sender_idle_pct = 0;
        hold_request    = 1'b1;
      end
      if (phase >= RANDOM_PHASES - 2) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      queue_random_text(PHASE_BYTES);
      drain();
    end

    if (mismatch_cnt == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
